### design/fes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fes_pkg - shared types and constants of the fire effect stencil unit
// Field widths, register map, divider constants and the item record that
// travels from the position front end into the stencil pipeline.
// ----------------------------------------------------------------------------
package fes_pkg;

  // Field widths
  localparam int HEAT_W       = 8;
  localparam int ROW_W        = 12;
  localparam int COL_OUT_W    = 10;
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 13;

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  localparam logic [CFG_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd320;
  localparam logic [CFG_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd200;
  localparam int MIN_WIDTH  = 3;
  localparam int MIN_HEIGHT = 3;
  localparam int MAX_HEIGHT = 4096;

  // Parameter defaults
  localparam int MAX_WIDTH_DEF    = 1024;
  localparam int PALETTE_SIZE_DEF = 256;

  // Stencil sum: weights 10,20,10 / 160,320,160 over 680 reduce to
  // (L + 2C + R + 16*(BL + 2B + BR)) / 68, sum at most 255*68.
  localparam int SUM_W       = 15;
  localparam int DIVISOR     = 68;
  localparam int RECIP       = 963;   // floor(2^16 / 68), quotient low by at most one
  localparam int RECIP_W     = 10;
  localparam int RECIP_SHIFT = 16;

  // Results caused by one item
  typedef enum logic [1:0] {
    EMIT_NONE = 2'd0,
    EMIT_ONE  = 2'd1,
    EMIT_TWO  = 2'd2
  } emit_kind_t;

  // Item record handed from the front end to the pipeline
  typedef struct packed {
    logic [HEAT_W-1:0]    heat;     // arriving heat, also heat of column 0 result
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] column;   // column of the first result
    logic                 border;   // first result passes held heat through
    emit_kind_t           kind;
  } item_t;

endpackage

### design/fes_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fes_ram - generic single-port RAM
// One address per cycle, read-first, registered read data.
// ----------------------------------------------------------------------------
module fes_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DATA_W-1:0]        wdata,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Old contents come out when the same entry is written
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/fes_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fes_cfg - configuration registers
// APB-style register file holding frame width and frame height.
// ----------------------------------------------------------------------------
module fes_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fes_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [fes_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [fes_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready,
  output logic [fes_pkg::CFG_WIDTH_W-1:0]     frame_width,
  output logic [fes_pkg::CFG_HEIGHT_W-1:0]    frame_height
);

  logic [fes_pkg::CFG_WIDTH_W-1:0]  frame_width_r;
  logic [fes_pkg::CFG_HEIGHT_W-1:0] frame_height_r;
  fes_pkg::reg_idx_t                reg_idx;
  logic                             wr_en;

  // Registers sit 4 bytes apart
  assign reg_idx = fes_pkg::reg_idx_t'(paddr[fes_pkg::CFG_ADDR_W-1]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= fes_pkg::FRAME_WIDTH_RST;
      frame_height_r <= fes_pkg::FRAME_HEIGHT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        fes_pkg::REG_FRAME_WIDTH: begin
          frame_width_r <= pwdata[fes_pkg::CFG_WIDTH_W-1:0];
        end
        fes_pkg::REG_FRAME_HEIGHT: begin
          frame_height_r <= pwdata[fes_pkg::CFG_HEIGHT_W-1:0];
        end
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      fes_pkg::REG_FRAME_WIDTH:  prdata = fes_pkg::CFG_DATA_W'(frame_width_r);
      fes_pkg::REG_FRAME_HEIGHT: prdata = fes_pkg::CFG_DATA_W'(frame_height_r);
    endcase
  end

  assign frame_width  = frame_width_r;
  assign frame_height = frame_height_r;

endmodule

### design/fes_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fes_pipe - stencil pipeline and result output
// Stage A adds up the stencil with the line buffer read data, stage B takes
// the reciprocal product, stage C corrects the quotient and emits one or two
// results into the output register; the palette is decoded from that register.
// ----------------------------------------------------------------------------
module fes_pipe #(
  parameter int PALETTE_SIZE = fes_pkg::PALETTE_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       item_valid,
  input  fes_pkg::item_t             item,
  input  logic [fes_pkg::HEAT_W-1:0] below,
  output logic                       take,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [55:0]                out_tdata,
  output logic                       out_tlast
);

  localparam int HW   = fes_pkg::HEAT_W;
  localparam int SW   = fes_pkg::SUM_W;
  localparam int PW   = fes_pkg::SUM_W + fes_pkg::RECIP_W;
  localparam int Seg  = PALETTE_SIZE / 3;
  localparam int Step = 255 / Seg;

  // Stage registers
  logic           a_valid_r, b_valid_r, c_valid_r, c_phase_r;
  fes_pkg::item_t a_item_r, b_item_r, c_item_r;
  logic [SW-1:0]  b_sum_r, c_sum_r;
  logic [HW-1:0]  b_pass_r, c_pass_r, c_q0_r;

  // Neighbor history, in stream order
  logic [HW-1:0]  hr_r, hfr_r, br_r, bfr_r;

  // Output register
  logic                             out_valid_r;
  logic [HW-1:0]                    out_heat_r;
  logic [fes_pkg::ROW_W-1:0]        out_row_r;
  logic [fes_pkg::COL_OUT_W-1:0]    out_col_r;
  logic                             out_last_r;

  logic          adv, slot_free, emit, second;
  logic [SW-1:0] sum_a, rem_c;
  logic [PW-1:0] prod_b;
  logic [HW-1:0] q0_b, q_c, heat1_c, res_heat;
  logic [fes_pkg::COL_OUT_W-1:0] res_col;
  logic          res_last;

  function automatic logic [SW-1:0] b_sum_fix(input logic [SW-1:0] s, input logic [HW-1:0] q);
    b_sum_fix = s - SW'(q) * SW'(fes_pkg::DIVISOR);
  endfunction

  // Stage A: stencil sum, weights divided down by ten
  assign sum_a = SW'(a_item_r.heat) + (SW'(hr_r) << 1) + SW'(hfr_r)
               + ((SW'(below) + (SW'(br_r) << 1) + SW'(bfr_r)) << 4);

  // Stage B: reciprocal multiply
  assign prod_b = PW'(b_sum_r) * PW'(fes_pkg::RECIP);
  assign q0_b   = HW'(prod_b >> fes_pkg::RECIP_SHIFT);

  // Stage C: quotient correction and result select
  assign rem_c   = b_sum_fix(c_sum_r, c_q0_r);
  assign q_c     = c_q0_r + HW'(rem_c >= SW'(fes_pkg::DIVISOR));
  assign heat1_c = c_item_r.border ? c_pass_r : q_c;

  assign second   = (c_item_r.kind == fes_pkg::EMIT_TWO) && c_phase_r;
  assign res_heat = second ? c_item_r.heat : heat1_c;
  assign res_col  = second ? '0 : c_item_r.column;
  assign res_last = !((c_item_r.kind == fes_pkg::EMIT_TWO) && !c_phase_r);

  // Flow control: the whole pipe shifts once stage C has delivered its results
  assign slot_free = !out_valid_r || out_tready;
  assign emit      = c_valid_r && (c_item_r.kind != fes_pkg::EMIT_NONE) && slot_free;
  assign adv       = !c_valid_r || (c_item_r.kind == fes_pkg::EMIT_NONE)
                   || (slot_free && ((c_item_r.kind == fes_pkg::EMIT_ONE) || c_phase_r));
  assign take      = adv;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      c_phase_r   <= 1'b0;
      out_valid_r <= 1'b0;
      hr_r        <= '0;
      hfr_r       <= '0;
      br_r        <= '0;
      bfr_r       <= '0;
    end else begin
      if (adv) begin
        a_valid_r <= item_valid;
        b_valid_r <= a_valid_r;
        c_valid_r <= b_valid_r;
        c_phase_r <= 1'b0;
      end else if (emit) begin
        c_phase_r <= 1'b1;
      end
      // history moves when an item leaves stage A
      if (adv && a_valid_r) begin
        hr_r  <= a_item_r.heat;
        hfr_r <= hr_r;
        br_r  <= below;
        bfr_r <= br_r;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (adv) begin
      a_item_r <= item;
      b_item_r <= a_item_r;
      b_sum_r  <= sum_a;
      b_pass_r <= hr_r;
      c_item_r <= b_item_r;
      c_sum_r  <= b_sum_r;
      c_pass_r <= b_pass_r;
      c_q0_r   <= q0_b;
    end
    if (emit) begin
      out_heat_r <= res_heat;
      out_row_r  <= c_item_r.row;
      out_col_r  <= res_col;
      out_last_r <= res_last;
    end
  end

  // Palette: three ramps, index clamped to the last entry
  logic [HW:0]   heat_ext;
  logic [HW-1:0] pal_idx, red, green, blue;
  logic [15:0]   ramp_r, ramp_g, ramp_b;

  always_comb begin
    heat_ext = {1'b0, out_heat_r};
    pal_idx  = (heat_ext >= (HW+1)'(PALETTE_SIZE)) ? HW'(PALETTE_SIZE - 1) : out_heat_r;
    ramp_r   = 16'(pal_idx) * 16'(Step);
    ramp_g   = 16'(pal_idx - HW'(Seg)) * 16'(Step);
    ramp_b   = 16'(pal_idx - HW'(2 * Seg)) * 16'(Step);
    priority if (pal_idx < HW'(Seg)) begin
      red   = ramp_r[HW-1:0];
      green = '0;
      blue  = '0;
    end else if (pal_idx < HW'(2 * Seg)) begin
      red   = '1;
      green = ramp_g[HW-1:0];
      blue  = '0;
    end else begin
      red   = '1;
      green = '1;
      blue  = (ramp_b > 16'd255) ? '1 : ramp_b[HW-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_col_r, out_row_r, blue, green, red, out_heat_r};

endmodule

### design/fire_effect_stencil_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fire_effect_stencil_unit - fire heat field stencil with palette
// Takes the heat field in reverse raster order, keeps the lower row in a
// line buffer and emits each cell's new heat, color and position.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  ---------+-----------+---------------------------------------------------
//  in_      | in        | tdata: heat_in; tuser: frame_start
//  out_     | out       | tdata: heat_out, rgb, row, column; tlast: run_last
//  cfg_     | in/out    | APB registers frame_width (0x0), frame_height (0x4)
//
//  One item accepted per cycle unless stalled; an item in column 0 yields
//  two results and holds the input while the first is emitted, since the
//  output register takes one result per cycle. An item passes stages A,
//  B, C and the output register. The line buffer is a read-first single-port
//  RAM: read and write of the same column happen in the accept cycle. Reset
//  needs no clearing pass. A stalled output holds its item in stage C and
//  drops in_tready at once; the stages ahead of it do not fill up.
// ----------------------------------------------------------------------------
module fire_effect_stencil_unit #(
  parameter int MAX_WIDTH    = fes_pkg::MAX_WIDTH_DEF,
  parameter int PALETTE_SIZE = fes_pkg::PALETTE_SIZE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] heat_in
  input  logic [0:0]                          in_tuser,   // [0] frame_start
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [55:0]                         out_tdata,  // [7:0] heat_out, [15:8] red,
                                                          // [23:16] green, [31:24] blue,
                                                          // [43:32] cell_row,
                                                          // [53:44] cell_column
  output logic                                out_tlast,  // run_last
  // configuration
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [fes_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [fes_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [fes_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);

  localparam int ColW    = $clog2(MAX_WIDTH);
  localparam int WExtW   = (ColW + 1 > fes_pkg::CFG_WIDTH_W) ? ColW + 1 : fes_pkg::CFG_WIDTH_W;
  localparam int CellW   = (ColW + 1 > fes_pkg::COL_OUT_W) ? ColW + 1 : fes_pkg::COL_OUT_W;
  localparam int HW      = fes_pkg::CFG_HEIGHT_W;
  localparam int RW      = fes_pkg::ROW_W;

  logic [fes_pkg::CFG_WIDTH_W-1:0]  frame_width;
  logic [fes_pkg::CFG_HEIGHT_W-1:0] frame_height;

  fes_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (cfg_psel),
    .penable      (cfg_penable),
    .pwrite       (cfg_pwrite),
    .paddr        (cfg_paddr),
    .pwdata       (cfg_pwdata),
    .prdata       (cfg_prdata),
    .pready       (cfg_pready),
    .frame_width  (frame_width),
    .frame_height (frame_height)
  );

  // Clamped frame size
  logic [WExtW-1:0] fw_ext;
  logic [ColW:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic [ColW-1:0]  col_last;
  logic [RW-1:0]    row_last;

  always_comb begin
    fw_ext = WExtW'(frame_width);
    priority if (fw_ext < WExtW'(fes_pkg::MIN_WIDTH)) begin
      w_eff = (ColW + 1)'(fes_pkg::MIN_WIDTH);
    end else if (fw_ext > WExtW'(MAX_WIDTH)) begin
      w_eff = (ColW + 1)'(MAX_WIDTH);
    end else begin
      w_eff = (ColW + 1)'(fw_ext);
    end
    priority if (frame_height < HW'(fes_pkg::MIN_HEIGHT)) begin
      h_eff = HW'(fes_pkg::MIN_HEIGHT);
    end else if (frame_height > HW'(fes_pkg::MAX_HEIGHT)) begin
      h_eff = HW'(fes_pkg::MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
    col_last = ColW'(w_eff - 1'b1);
    row_last = RW'(h_eff - 1'b1);
  end

  // Position of the arriving item
  logic [RW-1:0]   row_cnt_r, row;
  logic [ColW-1:0] col_cnt_r, col;
  logic            in_acc, start;

  assign start  = in_tuser[0];
  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    priority if (start) begin
      row = row_last;
      col = col_last;
    end else if (col_cnt_r == '0) begin
      col = col_last;
      row = (row_cnt_r == '0) ? row_last : row_cnt_r - 1'b1;
    end else begin
      col = col_cnt_r - 1'b1;
      row = row_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else if (in_acc) begin
      row_cnt_r <= row;
      col_cnt_r <= col;
    end
  end

  // Item record: result count, border test, first result's column
  logic [ColW:0]   col_ext;
  logic [CellW-1:0] cell_ext;
  logic            has_result, border;
  fes_pkg::item_t  item;

  always_comb begin
    col_ext    = {1'b0, col};
    cell_ext   = CellW'(col_ext) + 1'b1;
    has_result = col_ext < (w_eff - 1'b1);
    border     = (row == '0) || ((HW'(row) + 1'b1) >= h_eff) || ((col_ext + 2'd2) >= w_eff);
    item.heat   = in_tdata;
    item.row    = row;
    item.column = cell_ext[fes_pkg::COL_OUT_W-1:0];
    item.border = border;
    priority if (!has_result) begin
      item.kind = fes_pkg::EMIT_NONE;
    end else if (col == '0) begin
      item.kind = fes_pkg::EMIT_TWO;
    end else begin
      item.kind = fes_pkg::EMIT_ONE;
    end
  end

  // Line buffer: lower row, overwritten by the current row
  logic [fes_pkg::HEAT_W-1:0] below;

  fes_ram #(
    .DATA_W (fes_pkg::HEAT_W),
    .DEPTH  (MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .en    (in_acc),
    .we    (1'b1),
    .addr  (col),
    .wdata (in_tdata),
    .rdata (below)
  );

  fes_pipe #(
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_acc),
    .item       (item),
    .below      (below),
    .take       (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Assertions
  a_first_of_two_is_column_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[53:44] == 10'd1)
    else $error("non-final result not at column 1");

  a_second_follows_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tlast
      && out_tdata[53:44] == 10'd0)
    else $error("column 0 result did not follow column 1 result");

  a_frame_start_position: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && start |=> col_cnt_r == $past(col_last) && row_cnt_r == $past(row_last))
    else $error("frame start did not restart at bottom right");

endmodule
